// ===== src/skf_pkg.sv =====
`default_nettype none

package skf_pkg;

  // Datapath word: estimate, variance, noise registers and the transition factor.
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int GAIN_BITS  = 16;
  localparam int GAIN_W     = GAIN_BITS + 1;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int IN_W       = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_W      = ((DATA_WIDTH + GAIN_W + 7) / 8) * 8;
  localparam int CFG_ADDR_W = 2;
  localparam int DIV_STEPS  = GAIN_BITS + 1;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [DATA_WIDTH-1:0] ONE_Q    = DATA_WIDTH'(1) << FRAC_BITS;
  localparam logic [GAIN_W-1:0]     GAIN_ONE = GAIN_W'(1) << GAIN_BITS;
  localparam logic [DATA_WIDTH-1:0] SMAX_MAG = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] SMIN_MAG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PROCESS_NOISE   = 2'd0,
    CFG_MEASURE_NOISE   = 2'd1,
    CFG_TRANSITION_GAIN = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_XM,
    MUL_A2,
    MUL_PM,
    MUL_CORR,
    MUL_VAR
  } mul_op_t;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_XM,
    WB_A2,
    WB_PM,
    WB_CORR,
    WB_EST,
    WB_VAR
  } wb_op_t;

  typedef struct packed {
    logic    load;
    mul_op_t mul_op;
    wb_op_t  wb_op;
    logic    div_init;
    logic    div_step;
    logic    div_shift;
    logic    out_load;
  } skf_cmd_t;

  typedef struct packed {
    logic out_busy;
  } skf_stat_t;

  function automatic logic [DATA_WIDTH-1:0] mag_f(input logic [DATA_WIDTH-1:0] v);
    return v[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - v) : v;
  endfunction

endpackage

`default_nettype wire

// ===== src/scalar_kalman_filter.sv =====
`default_nettype none

// One-dimensional Kalman filter in signed Q16.16. Each input beat carries one
// measurement; each output beat returns the corrected estimate (saturated) and
// the Q1.16 gain used for that step. Estimate and variance clear at reset, and
// the transition factor resets to 1.0. Configuration is to be written by the user
// through the cfg_ port only while no measurement is in flight; the block itself
// does not enforce this. No new measurement is taken until the current one is
// finished, and the result is held back until the previous result beat has been
// taken. Five products go through a single 32x32 multiplier, each followed by a
// scaling and saturation step, and the gain comes from a restoring divider that
// produces one quotient bit per cycle.
module scalar_kalman_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [skf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [skf_pkg::DATA_WIDTH-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [skf_pkg::IN_W-1:0]       in_tdata,   // [31:0] measurement
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [skf_pkg::OUT_W-1:0]      out_tdata   // [31:0] estimate_out, [48:32] gain_out
);
  import skf_pkg::*;

  skf_cmd_t  cmd;
  skf_stat_t stat;

  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  skf_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a measurement is in flight");

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[DATA_WIDTH+GAIN_W-1:DATA_WIDTH] <= GAIN_ONE))
    else $error("gain above 1.0");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result beat without a measurement in flight");

endmodule

`default_nettype wire

// ===== src/skf_ctrl.sv =====
`default_nettype none

module skf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  skf_pkg::skf_stat_t stat,
  output skf_pkg::skf_cmd_t  cmd
);
  import skf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MXM,
    S_WXM,
    S_MA2,
    S_WA2,
    S_MPM,
    S_WPM,
    S_DINIT,
    S_DIV,
    S_MCORR,
    S_WCORR,
    S_EST,
    S_WVAR,
    S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.mul_op    = MUL_NONE;
    cmd.wb_op     = WB_NONE;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_tvalid;
        if (in_tvalid) state_nxt = S_MXM;
      end
      S_MXM: begin
        cmd.mul_op = MUL_XM;
        state_nxt  = S_WXM;
      end
      S_WXM: begin
        cmd.wb_op = WB_XM;
        state_nxt = S_MA2;
      end
      S_MA2: begin
        cmd.mul_op = MUL_A2;
        state_nxt  = S_WA2;
      end
      S_WA2: begin
        cmd.wb_op = WB_A2;
        state_nxt = S_MPM;
      end
      S_MPM: begin
        cmd.mul_op = MUL_PM;
        state_nxt  = S_WPM;
      end
      S_WPM: begin
        cmd.wb_op = WB_PM;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        // The first step decides the integer bit of the gain without a shift.
        cmd.div_step  = 1'b1;
        cmd.div_shift = (cnt_r != '0);
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = S_MCORR;
      end
      S_MCORR: begin
        cmd.mul_op = MUL_CORR;
        state_nxt  = S_WCORR;
      end
      S_WCORR: begin
        cmd.wb_op = WB_CORR;
        state_nxt = S_EST;
      end
      S_EST: begin
        cmd.wb_op  = WB_EST;
        cmd.mul_op = MUL_VAR;
        state_nxt  = S_WVAR;
      end
      S_WVAR: begin
        cmd.wb_op = WB_VAR;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/skf_datapath.sv =====
`default_nettype none

module skf_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [skf_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [skf_pkg::DATA_WIDTH-1:0]      cfg_wdata,
  input  logic [skf_pkg::IN_W-1:0]            in_tdata,
  input  skf_pkg::skf_cmd_t                   cmd,
  output skf_pkg::skf_stat_t                  stat,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [skf_pkg::OUT_W-1:0]           out_tdata
);
  import skf_pkg::*;

  localparam int DW = DATA_WIDTH;

  logic [DW-1:0]     q_noise_r, r_noise_r, a_gain_r;
  logic [DW-1:0]     est_r, var_r;
  logic [DW-1:0]     z_r, xm_r, a2_r, pm_r, corr_r;
  logic [DW-1:0]     innov_mag_r;
  logic              innov_neg_r;
  logic [PROD_W-1:0] prod_r;
  logic              neg_r;
  logic [DW:0]       den_r;
  logic [DW+1:0]     rem_r;
  logic [GAIN_W-1:0] quo_r;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  logic [DW-1:0]     mul_a, mul_b;
  logic              mul_neg;
  logic [GAIN_W-1:0] gain;
  logic [PROD_W-1:0] sh;
  logic              ovf;
  logic [DW-1:0]     u_res, s_lim, s_mag, s_res;
  logic [DW:0]       pm_sum, est_sum, diff;
  logic [DW+1:0]     rem_s;

  assign gain = (den_r == '0) ? '0 : quo_r;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (cmd.mul_op)
      MUL_XM: begin
        mul_a   = mag_f(a_gain_r);
        mul_b   = mag_f(est_r);
        mul_neg = a_gain_r[DW-1] ^ est_r[DW-1];
      end
      MUL_A2: begin
        mul_a = mag_f(a_gain_r);
        mul_b = mag_f(a_gain_r);
      end
      MUL_PM: begin
        mul_a = a2_r;
        mul_b = var_r;
      end
      MUL_CORR: begin
        mul_a   = DW'(gain);
        mul_b   = innov_mag_r;
        mul_neg = innov_neg_r;
      end
      MUL_VAR: begin
        mul_a = pm_r;
        mul_b = DW'(GAIN_ONE - gain);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // Scale the registered product, truncating its magnitude, then saturate.
  always_comb begin
    if (cmd.wb_op == WB_CORR || cmd.wb_op == WB_VAR) sh = prod_r >> GAIN_BITS;
    else                                             sh = prod_r >> FRAC_BITS;
    ovf   = |sh[PROD_W-1:DW];
    u_res = ovf ? '1 : sh[DW-1:0];
    s_lim = neg_r ? SMIN_MAG : SMAX_MAG;
    s_mag = (ovf || (sh[DW-1:0] > s_lim)) ? s_lim : sh[DW-1:0];
    s_res = neg_r ? (DW'(0) - s_mag) : s_mag;
  end

  assign pm_sum  = {1'b0, u_res} + {1'b0, q_noise_r};
  assign est_sum = {xm_r[DW-1], xm_r} + {corr_r[DW-1], corr_r};
  assign diff    = {z_r[DW-1], z_r} - {xm_r[DW-1], xm_r};
  assign rem_s   = cmd.div_shift ? {rem_r[DW:0], 1'b0} : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_noise_r   <= '0;
      r_noise_r   <= '0;
      a_gain_r    <= ONE_Q;
      est_r       <= '0;
      var_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_PROCESS_NOISE:   q_noise_r <= cfg_wdata;
          CFG_MEASURE_NOISE:   r_noise_r <= cfg_wdata;
          CFG_TRANSITION_GAIN: a_gain_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (cmd.wb_op == WB_EST) begin
        if (est_sum[DW] != est_sum[DW-1]) est_r <= est_sum[DW] ? SMIN_MAG : SMAX_MAG;
        else                              est_r <= est_sum[DW-1:0];
      end
      if (cmd.wb_op == WB_VAR) var_r <= u_res;
      if (cmd.out_load)     out_valid_r <= 1'b1;
      else if (out_tready)  out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) z_r <= in_tdata[DW-1:0];
    if (cmd.mul_op != MUL_NONE) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
      neg_r  <= mul_neg;
    end
    case (cmd.wb_op)
      WB_XM:   xm_r   <= s_res;
      WB_A2:   a2_r   <= u_res;
      WB_PM:   pm_r   <= pm_sum[DW] ? '1 : pm_sum[DW-1:0];
      WB_CORR: corr_r <= s_res;
      default: begin
      end
    endcase
    if (cmd.div_init) begin
      den_r       <= {1'b0, pm_r} + {1'b0, r_noise_r};
      rem_r       <= {2'b00, pm_r};
      quo_r       <= '0;
      innov_neg_r <= diff[DW];
      innov_mag_r <= diff[DW] ? DW'(-diff) : diff[DW-1:0];
    end else if (cmd.div_step) begin
      if (rem_s >= {1'b0, den_r}) begin
        rem_r <= rem_s - {1'b0, den_r};
        quo_r <= {quo_r[GAIN_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_s;
        quo_r <= {quo_r[GAIN_W-2:0], 1'b0};
      end
    end
    if (cmd.out_load) out_data_r <= OUT_W'({gain, est_r});
  end

  assign stat.out_busy = out_valid_r && !out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import skf_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES  = 40;

  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_IDX = 2'd3;

  localparam longint          EST_MAX  = 64'sd2147483647;
  localparam longint          EST_MIN  = -64'sd2147483648;
  localparam longint unsigned VAR_MAX  = (64'd1 << DATA_WIDTH) - 64'd1;
  localparam longint unsigned UNITY_K  = 64'd1 << GAIN_BITS;

  typedef enum int {
    STALL_NONE,
    STALL_SHORT,
    STALL_LONG
  } stall_mode_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] estimate;
    logic [GAIN_W-1:0]     gain;
  } kalman_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [DATA_WIDTH-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;

  scalar_kalman_filter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Filter state and registers as the block should hold them.
  longint                 est_q;
  longint unsigned        var_q;
  logic [DATA_WIDTH-1:0]  q_noise;
  logic [DATA_WIDTH-1:0]  r_noise;
  logic signed [DATA_WIDTH-1:0] a_gain;

  kalman_result_t expected_estimates[$];

  int unsigned mismatch_count    = 0;
  int unsigned results_checked   = 0;
  int unsigned measurements_sent = 0;
  int unsigned settings_applied  = 0;
  int unsigned quiet_cycles      = 0;

  stall_mode_t stall_mode    = STALL_NONE;
  bit          sender_bursty = 1'b0;
  int unsigned burst_left    = 0;
  longint      signal_center = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned magnitude(longint v);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    return m;
  endfunction

  // Exact unsigned product shifted right, clipped to lim.
  function automatic longint unsigned scaled_product(longint unsigned a, longint unsigned b,
                                                     int sh, longint unsigned lim);
    logic [127:0] p;
    p = (128'(a) * 128'(b)) >> sh;
    return (p > 128'(lim)) ? lim : p[63:0];
  endfunction

  // Signed product truncated toward zero and saturated to the data word.
  function automatic longint signed_scaled_product(longint a, longint b, int sh);
    bit              neg;
    longint unsigned lim;
    longint unsigned m;
    neg = (a < 0) != (b < 0);
    lim = neg ? longint'(-EST_MIN) : longint'(EST_MAX);
    m   = scaled_product(magnitude(a), magnitude(b), sh, lim);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic kalman_result_t filter_step(logic [DATA_WIDTH-1:0] z_bits);
    longint          a;
    longint          z;
    longint          xm;
    longint          xn;
    longint          corr;
    longint unsigned a2;
    longint unsigned pm;
    longint unsigned den;
    longint unsigned k;
    kalman_result_t  r;
    a  = a_gain;
    z  = longint'($signed(z_bits));
    xm = signed_scaled_product(a, est_q, FRAC_BITS);
    a2 = scaled_product(magnitude(a), magnitude(a), FRAC_BITS, VAR_MAX);
    pm = scaled_product(a2, var_q, FRAC_BITS, VAR_MAX) + {32'd0, q_noise};
    if (pm > VAR_MAX) pm = VAR_MAX;
    den = pm + {32'd0, r_noise};
    k   = (den == 0) ? 64'd0 : (pm << GAIN_BITS) / den;
    corr = signed_scaled_product(longint'(k), z - xm, GAIN_BITS);
    xn = xm + corr;
    if (xn > EST_MAX) xn = EST_MAX;
    if (xn < EST_MIN) xn = EST_MIN;
    est_q = xn;
    var_q = scaled_product(pm, UNITY_K - k, GAIN_BITS, VAR_MAX);
    r.estimate = DATA_WIDTH'(xn);
    r.gain     = GAIN_W'(k);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] expected, logic [63:0] actual);
    $display("ERROR %0t: %s expected %h got %h", $time, field, expected, actual);
    mismatch_count++;
  endtask

  // One measurement beat; the prediction is taken at the accepting edge.
  task automatic send_measurement(logic [DATA_WIDTH-1:0] z);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata  <= z;
    do @(posedge clk); while (!in_tready);
    expected_estimates.push_back(filter_step(z));
    measurements_sent++;
    if (sender_bursty) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap        = $urandom_range(1, 24);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold the input off until every pending estimate has come back.
  task automatic wait_until_idle();
    in_tvalid <= 1'b0;
    while (expected_estimates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges with cfg_we held high.
  task automatic program_filter(logic [DATA_WIDTH-1:0] q, logic [DATA_WIDTH-1:0] r,
                                logic [DATA_WIDTH-1:0] a, bit poke_unused);
    cfg_we <= 1'b1;
    if (poke_unused) begin
      cfg_addr  <= CFG_UNUSED_IDX;
      cfg_wdata <= $urandom;
      @(posedge clk);
    end
    cfg_addr  <= CFG_PROCESS_NOISE;
    cfg_wdata <= q;
    @(posedge clk);
    cfg_addr  <= CFG_MEASURE_NOISE;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_addr  <= CFG_TRANSITION_GAIN;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_we  <= 1'b0;
    q_noise = q;
    r_noise = r;
    a_gain  = a;
    settings_applied++;
  endtask

  // Mostly a noisy, slowly wandering signal, with some full-range and extreme samples.
  function automatic logic [DATA_WIDTH-1:0] next_measurement();
    int unsigned kind;
    int unsigned spread;
    longint      noise;
    kind = $urandom_range(0, 9);
    signal_center = signal_center + longint'($urandom_range(0, 2048)) - 1024;
    if (kind == 0) return $urandom;
    if (kind == 1) begin
      case ($urandom_range(0, 3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    spread = $urandom_range(4, 24);
    noise  = longint'($urandom_range(0, 32'd1 << (spread + 1))) - (longint'(1) << spread);
    return DATA_WIDTH'(signal_center + noise);
  endfunction

  task automatic test_zero_denominator();
    // Reset registers: no noise at all, so the gain stays zero.
    send_measurement(32'h7FFF_FFFF);
    send_measurement(32'h8000_0000);
    send_measurement(32'h0000_0001);
    send_measurement(32'hFFFF_FFFF);
  endtask

  task automatic test_full_gain();
    // No measurement noise: the gain is 1.0 and the estimate follows each sample unless the correction saturates.
    wait_until_idle();
    program_filter(32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 1'b1);
    send_measurement(32'h7FFF_FFFF);
    send_measurement(32'h8000_0000);
    send_measurement(32'h1234_5678);
    send_measurement(32'h0000_0000);
  endtask

  task automatic test_saturation();
    stall_mode = STALL_SHORT;
    wait_until_idle();
    program_filter(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_measurement(32'h7FFF_FFFF);
    send_measurement(32'h7FFF_FFFF);
    send_measurement(32'h8000_0000);
    send_measurement(32'h8000_0000);
    send_measurement(32'h7FFF_FFFF);
    wait_until_idle();
    program_filter(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 1'b0);
    send_measurement(32'h7FFF_FFFF);
    send_measurement(32'h8000_0000);
    send_measurement(32'h7FFF_FFFF);
    send_measurement(32'h0000_0000);
  endtask

  task automatic test_negative_transition();
    stall_mode    = STALL_LONG;
    sender_bursty = 1'b1;
    wait_until_idle();
    program_filter(32'h0000_8000, 32'h0001_0000, 32'hFFFF_0000, 1'b0);
    send_measurement(32'h0003_0000);
    send_measurement(32'hFFFD_0000);
    send_measurement(32'h0003_0000);
    send_measurement(32'h7FFF_FFFF);
    send_measurement(32'h8000_0000);
    // A zero factor with no noise clears the variance and returns to a zero gain.
    wait_until_idle();
    program_filter(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_measurement(32'h0001_0000);
    send_measurement(32'hFFFF_0000);
  endtask

  task automatic test_random_tracking();
    logic [DATA_WIDTH-1:0] q;
    logic [DATA_WIDTH-1:0] r;
    logic [DATA_WIDTH-1:0] a;
    int unsigned           phase_items;
    int unsigned           sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 4))
        0: q = 32'h0000_0000;
        1: q = $urandom;
        2: q = 32'hFFFF_FFFF;
        default: q = $urandom_range(0, 32'h0004_0000);
      endcase
      case ($urandom_range(0, 5))
        0: r = 32'h0000_0000;
        1: r = $urandom;
        2: r = 32'hFFFF_FFFF;
        default: r = $urandom_range(1, 32'h0010_0000);
      endcase
      case ($urandom_range(0, 7))
        0: a = $urandom;
        1: a = 32'h7FFF_FFFF;
        2: a = 32'h8000_0000;
        3: a = 32'hFFFF_0000;
        4: a = 32'h0001_0000;
        default: a = 32'h0000_C000 + $urandom_range(0, 32'h0000_8000);
      endcase
      stall_mode    = stall_mode_t'($urandom_range(0, 2));
      sender_bursty = ($urandom_range(0, 3) != 0);
      wait_until_idle();
      program_filter(q, r, a, $urandom_range(0, 7) == 0);
      phase_items = $urandom_range(40, 160);
      repeat (phase_items) send_measurement(next_measurement());
      sent += phase_items;
    end
  endtask

  // Receiver: always ready without stalls, else alternating ready and stall runs whose lengths depend on the mode.
  initial begin
    int unsigned run_left;
    bit          run_ready;
    run_left  = 0;
    run_ready = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (run_left == 0) begin
        run_ready = !run_ready;
        case (stall_mode)
          STALL_NONE: begin
            run_ready = 1'b1;
            run_left  = 1;
          end
          STALL_SHORT: run_left = run_ready ? $urandom_range(1, 6) : $urandom_range(1, 4);
          default:     run_left = run_ready ? $urandom_range(1, 3) : $urandom_range(5, 40);
        endcase
      end
      run_left--;
      out_tready <= run_ready;
    end
  end

  always @(posedge clk) begin
    kalman_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (expected_estimates.size() == 0) begin
        report_mismatch("unexpected result beat", 64'd0, 64'(out_tdata));
      end else begin
        want = expected_estimates.pop_front();
        if (out_tdata[DATA_WIDTH-1:0] !== want.estimate)
          report_mismatch("estimate_out", 64'(want.estimate), 64'(out_tdata[DATA_WIDTH-1:0]));
        if (out_tdata[DATA_WIDTH +: GAIN_W] !== want.gain)
          report_mismatch("gain_out", 64'(want.gain), 64'(out_tdata[DATA_WIDTH +: GAIN_W]));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= CFG_PROCESS_NOISE;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    est_q   = 0;
    var_q   = 0;
    q_noise = '0;
    r_noise = '0;
    a_gain  = ONE_Q;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_denominator();
    test_full_gain();
    test_saturation();
    test_negative_transition();
    test_random_tracking();

    wait_until_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_estimates.size() != 0)
      report_mismatch("estimates never returned", 64'(expected_estimates.size()), 64'd0);

    $display("Checked %0d estimates for %0d measurements across %0d filter settings.",
             results_checked, measurements_sent, settings_applied + 1);
    $display("Settings spanned zero and full-scale noise and extreme transition factors.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
